// ===== rtl/hsv2rgb_pkg.sv =====
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W       = 15;
    localparam int CH_W        = 8;
    localparam int SEC_W       = 4;
    localparam int REM_W       = 12;
    localparam int PROD_W      = 2 * CH_W;
    localparam int NUM_SECTORS = 8;
    localparam int SECTOR_SPAN = 3840;
    localparam int STAGES      = 5;

    // floor(x / 15) = (x * 17477) >> 18 for x < 3840
    localparam int RECIP15       = 17477;
    localparam int RECIP15_W     = 15;
    localparam int RECIP15_SHIFT = 18;

    localparam logic [SEC_W-1:0] SECTOR_0 = 4'd0;
    localparam logic [SEC_W-1:0] SECTOR_1 = 4'd1;
    localparam logic [SEC_W-1:0] SECTOR_2 = 4'd2;
    localparam logic [SEC_W-1:0] SECTOR_3 = 4'd3;
    localparam logic [SEC_W-1:0] SECTOR_4 = 4'd4;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // floor(x / 255) for 16-bit x below 65280, which covers any product of two 8-bit values
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + {{(CH_W+1){1'b0}}, x[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
        return sum[PROD_W-1:CH_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// 5 register stages, r1 through r5; o_valid is the valid bit of stage 5.
// Throughput: one item per cycle while i_ready stays high; stages advance
// independently, so bubbles are squeezed out and a stalled output stalls
// only the stages behind it. Depth is set by the divide-by-3840 sector
// split, the divide-by-15 multiply, the two multiply stages and the
// divide-by-255 with sector select. Reset (synchronous, active low) clears
// all valid bits.
`default_nettype none

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [HUE_W-1:0]  i_hue,
    input  wire logic [CH_W-1:0]   i_saturation,
    input  wire logic [CH_W-1:0]   i_brightness,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CH_W-1:0]        o_red,
    output logic [CH_W-1:0]        o_green,
    output logic [CH_W-1:0]        o_blue
);

    logic [STAGES:1] r_vld;
    logic [STAGES:1] en;

    // stage 1
    logic [SEC_W-1:0]  r1_sec;
    logic [REM_W-1:0]  r1_rem;
    logic [CH_W-1:0]   r1_s, r1_v;
    // stage 2
    logic [SEC_W-1:0]  r2_sec;
    logic [CH_W-1:0]   r2_f, r2_s, r2_v;
    // stage 3
    logic [SEC_W-1:0]  r3_sec;
    logic [CH_W-1:0]   r3_v;
    logic [PROD_W-1:0] r3_sf, r3_st, r3_pp;
    // stage 4
    logic [SEC_W-1:0]  r4_sec;
    logic [CH_W-1:0]   r4_v, r4_p;
    logic [PROD_W-1:0] r4_pq, r4_pt;
    // stage 5
    logic [CH_W-1:0]   r5_r, r5_g, r5_b;

    logic [SEC_W-1:0]  n1_sec;
    logic [HUE_W-1:0]  n1_base;
    logic [HUE_W-1:0]  n1_diff;
    logic [REM_W+RECIP15_W-1:0] n2_prod;
    logic [PROD_W:0]   n3_st;
    logic [CH_W-1:0]   n4_qf, n4_tf;
    logic [CH_W-1:0]   n5_q, n5_t;
    logic [CH_W-1:0]   n5_r, n5_g, n5_b;

    always_comb begin
        en[STAGES] = !r_vld[STAGES] || i_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[1];
    assign o_valid = r_vld[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n1_sec  = SECTOR_0;
        n1_base = '0;
        for (int k = 1; k <= NUM_SECTORS; k++) begin
            if (i_hue >= HUE_W'(k * SECTOR_SPAN)) begin
                n1_sec  = SEC_W'(k);
                n1_base = HUE_W'(k * SECTOR_SPAN);
            end
        end
        n1_diff = i_hue - n1_base;
    end

    assign n2_prod = {{RECIP15_W{1'b0}}, r1_rem} * (REM_W + RECIP15_W)'(RECIP15);
    assign n3_st   = (PROD_W + 1)'(r2_s) * ((PROD_W + 1)'(256) - (PROD_W + 1)'(r2_f));
    assign n4_qf   = CH_MAX - r3_sf[PROD_W-1:CH_W];
    assign n4_tf   = CH_MAX - r3_st[PROD_W-1:CH_W];
    assign n5_q    = div255(r4_pq);
    assign n5_t    = div255(r4_pt);

    always_comb begin
        unique case (r4_sec)
            SECTOR_0: begin n5_r = r4_v; n5_g = n5_t; n5_b = r4_p; end
            SECTOR_1: begin n5_r = n5_q; n5_g = r4_v; n5_b = r4_p; end
            SECTOR_2: begin n5_r = r4_p; n5_g = r4_v; n5_b = n5_t; end
            SECTOR_3: begin n5_r = r4_p; n5_g = n5_q; n5_b = r4_v; end
            SECTOR_4: begin n5_r = n5_t; n5_g = r4_p; n5_b = r4_v; end
            default:  begin n5_r = r4_v; n5_g = r4_p; n5_b = n5_q; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_sec <= n1_sec;
            r1_rem <= n1_diff[REM_W-1:0];
            r1_s   <= i_saturation;
            r1_v   <= i_brightness;
        end
        if (en[2]) begin
            r2_sec <= r1_sec;
            r2_f   <= n2_prod[RECIP15_SHIFT+CH_W-1:RECIP15_SHIFT];
            r2_s   <= r1_s;
            r2_v   <= r1_v;
        end
        if (en[3]) begin
            r3_sec <= r2_sec;
            r3_v   <= r2_v;
            r3_sf  <= PROD_W'(r2_s) * PROD_W'(r2_f);
            r3_st  <= n3_st[PROD_W-1:0];
            r3_pp  <= PROD_W'(r2_v) * PROD_W'(CH_MAX - r2_s);
        end
        if (en[4]) begin
            r4_sec <= r3_sec;
            r4_v   <= r3_v;
            r4_p   <= div255(r3_pp);
            r4_pq  <= PROD_W'(r3_v) * PROD_W'(n4_qf);
            r4_pt  <= PROD_W'(r3_v) * PROD_W'(n4_tf);
        end
        if (en[5]) begin
            r5_r <= n5_r;
            r5_g <= n5_g;
            r5_b <= n5_b;
        end
    end

    assign o_red   = r5_r;
    assign o_green = r5_g;
    assign o_blue  = r5_b;

endmodule

`default_nettype wire

// ===== tb/hsv_to_rgb_converter_tb.sv =====
`default_nettype none

module hsv_to_rgb_converter_tb;
    import hsv2rgb_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HUE_TOP      = 6 * SECTOR_SPAN - 1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [HUE_W-1:0]  hue;
    logic [CH_W-1:0]   saturation;
    logic [CH_W-1:0]   brightness;
    logic              out_valid;
    logic              out_ready;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;

    t_rgb expected_rgb[$];
    int   mismatches;
    int   quiet_cycles;
    int   send_idle_pct;
    int   recv_idle_pct;

    hsv_to_rgb_converter dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_hue        (hue),
        .i_saturation (saturation),
        .i_brightness (brightness),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic t_rgb convert_hsv(input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s,
                                         input logic [CH_W-1:0] v);
        int unsigned     frac;
        int unsigned     p;
        int unsigned     q;
        int unsigned     t;
        logic [SEC_W-1:0] sector;
        t_rgb            px;
        sector = SEC_W'(h / SECTOR_SPAN);
        frac   = (h % SECTOR_SPAN) / 15;
        p = (v * (255 - s)) / 255;
        q = (v * (255 - ((s * frac) >> 8))) / 255;
        t = (v * (255 - ((s * (256 - frac)) >> 8))) / 255;
        if (s == 0) begin
            px = '{v, v, v};
        end else begin
            case (sector)
                SECTOR_0: px = '{v, CH_W'(t), CH_W'(p)};
                SECTOR_1: px = '{CH_W'(q), v, CH_W'(p)};
                SECTOR_2: px = '{CH_W'(p), v, CH_W'(t)};
                SECTOR_3: px = '{CH_W'(p), CH_W'(q), v};
                SECTOR_4: px = '{CH_W'(t), CH_W'(p), v};
                default:  px = '{v, CH_W'(p), CH_W'(q)};
            endcase
        end
        return px;
    endfunction

    task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s,
                              input logic [CH_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        hue        = h;
        saturation = s;
        brightness = v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_rgb = {expected_rgb, convert_hsv(h, s, v)};
    endtask

    task automatic test_grey_pixels;
        send_pixel(0, 0, 0);
        send_pixel(12345, 0, 255);
        send_pixel(32767, 0, 128);
    endtask

    task automatic test_sector_edges;
        for (int k = 0; k < 6; k++) begin
            send_pixel(HUE_W'(k * SECTOR_SPAN), 255, 255);
            send_pixel(HUE_W'(k * SECTOR_SPAN + SECTOR_SPAN - 1), 255, 255);
        end
    endtask

    task automatic test_field_extremes;
        send_pixel(0, 255, 0);
        send_pixel(HUE_TOP, 1, 255);
        send_pixel(32767, 255, 255);
        send_pixel(21845, 170, 85);
    endtask

    task automatic test_hue_past_range;
        send_pixel(HUE_W'(6 * SECTOR_SPAN), 200, 200);
        send_pixel(HUE_W'(7 * SECTOR_SPAN + 1234), 200, 200);
        send_pixel(HUE_W'(8 * SECTOR_SPAN), 200, 200);
    endtask

    task automatic test_random_pixels(input int count);
        logic [HUE_W-1:0] h;
        logic [CH_W-1:0]  s;
        logic [CH_W-1:0]  v;
        for (int n = 0; n < count; n++) begin
            h = ($urandom_range(99) < 85) ? HUE_W'($urandom_range(HUE_TOP))
                                          : HUE_W'($urandom);
            case ($urandom_range(9))
                0:       s = 8'd0;
                1:       s = 8'd255;
                2:       s = 8'd1;
                default: s = CH_W'($urandom);
            endcase
            case ($urandom_range(9))
                0:       v = 8'd0;
                1:       v = 8'd255;
                default: v = CH_W'($urandom);
            endcase
            send_pixel(h, s, v);
        end
    endtask

    always @(negedge clk) begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        t_rgb want;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (expected_rgb.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, actual %0d %0d %0d",
                             $time, red, green, blue);
                    mismatches++;
                end else begin
                    want = expected_rgb.pop_front();
                    if (red !== want.red) begin
                        $display("%0t: red mismatch, expected %0d, actual %0d",
                                 $time, want.red, red);
                        mismatches++;
                    end
                    if (green !== want.green) begin
                        $display("%0t: green mismatch, expected %0d, actual %0d",
                                 $time, want.green, green);
                        mismatches++;
                    end
                    if (blue !== want.blue) begin
                        $display("%0t: blue mismatch, expected %0d, actual %0d",
                                 $time, want.blue, blue);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        hue           = '0;
        saturation    = '0;
        brightness    = '0;
        out_ready     = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 32;
        recv_idle_pct = 85;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_grey_pixels();
        test_sector_edges();
        test_field_extremes();
        test_hue_past_range();
        test_random_pixels(360);

        send_idle_pct = 85;
        recv_idle_pct = 32;
        test_random_pixels(360);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pixels(360);

        @(negedge clk);
        in_valid = 1'b0;
        while (expected_rgb.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
